### rtl/rffsa_pkg.sv
// Shared types and constants for the row first-fit seat allocator.
package rffsa_pkg;

    localparam int ROWS      = 1024;
    localparam int ROW_W     = $clog2(ROWS);
    localparam int RCNT_W    = ROW_W + 1;
    localparam int SEAT_W    = 16;
    localparam int CNT_W     = 26;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEATS_PER_ROW = 1'b1;

    localparam logic CMD_CONTIG  = 1'b0;
    localparam logic CMD_SCATTER = 1'b1;

    typedef struct packed {
        logic              command;
        logic [CNT_W-1:0]  seat_count;
        logic [ROW_W-1:0]  max_row;
    } t_req;

    typedef struct packed {
        logic              granted;
        logic [ROW_W-1:0]  row;
        logic [SEAT_W-1:0] first_seat;
    } t_rsp;

    typedef struct packed {
        logic clr_init;
        logic clr_step;
        logic start;
        logic rd;
        logic ev;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic finish;
        logic out_free;
    } t_sts;

endpackage

### rtl/rffsa_ctrl.sv
// Sequencer for clearing, row scans and result hand-off.
module rffsa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  rffsa_pkg::t_sts   i_sts,
    output rffsa_pkg::t_cmd   o_cmd
);

    typedef enum logic [4:0] {
        S_CLR  = 5'b00001,
        S_IDLE = 5'b00010,
        S_RD   = 5'b00100,
        S_EV   = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state, n_state;

    assign o_in_stall = (r_state != S_IDLE) || i_cfg_we;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        if (i_cfg_we) begin
            o_cmd.clr_init = 1'b1;
            n_state        = S_CLR;
        end else begin
            unique case (r_state)
                S_CLR: begin
                    o_cmd.clr_step = 1'b1;
                    if (i_sts.clr_last) n_state = S_IDLE;
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_RD;
                    end
                end
                S_RD: begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_EV;
                end
                S_EV: begin
                    o_cmd.ev = 1'b1;
                    n_state  = i_sts.finish ? S_DONE : S_RD;
                end
                S_DONE: begin
                    if (i_sts.out_free) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_IDLE;
                    end
                end
                default: n_state = S_CLR;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_CLR;
        else          r_state <= n_state;
    end

endmodule

### rtl/rffsa_dp.sv
// Row count memory, config registers, scan arithmetic and result register.
module rffsa_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [rffsa_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [rffsa_pkg::SEAT_W-1:0]       i_cfg_data,
    input  rffsa_pkg::t_req                    i_req,
    input  logic                               i_out_stall,
    output logic                               o_out_valid,
    output rffsa_pkg::t_rsp                    o_rsp,
    input  rffsa_pkg::t_cmd                    i_cmd,
    output rffsa_pkg::t_sts                    o_sts
);

    logic [rffsa_pkg::SEAT_W-1:0] mem [rffsa_pkg::ROWS];

    logic [rffsa_pkg::RCNT_W-1:0] r_rows;
    logic [rffsa_pkg::SEAT_W-1:0] r_spr;
    logic [rffsa_pkg::ROW_W-1:0]  r_idx, n_idx;
    logic [rffsa_pkg::ROW_W-1:0]  r_top;
    logic                         r_mode;
    logic                         r_fill, n_fill;
    logic [rffsa_pkg::CNT_W-1:0]  r_k, n_k;
    logic [rffsa_pkg::CNT_W-1:0]  r_sum, n_sum;
    logic [rffsa_pkg::CNT_W-1:0]  r_cap;
    logic [rffsa_pkg::SEAT_W-1:0] r_rdata;
    rffsa_pkg::t_rsp              r_res, n_res;
    logic                         r_ovalid;
    rffsa_pkg::t_rsp              r_out;

    logic [rffsa_pkg::ROW_W-1:0]  act_m1, top_c;
    logic [rffsa_pkg::CNT_W:0]    need;
    logic [rffsa_pkg::CNT_W:0]    sum_k;
    logic [rffsa_pkg::CNT_W-1:0]  sum_new;
    logic [rffsa_pkg::SEAT_W-1:0] avail, take;
    logic                         at_top, fin, wr;
    logic [rffsa_pkg::SEAT_W-1:0] wdata;

    // clamp of the row limit
    always_comb begin
        if (r_rows == '0)
            act_m1 = '0;
        else if (r_rows > rffsa_pkg::RCNT_W'(rffsa_pkg::ROWS))
            act_m1 = rffsa_pkg::ROW_W'(rffsa_pkg::ROWS - 1);
        else
            act_m1 = rffsa_pkg::ROW_W'(r_rows - 1'b1);
        top_c = (i_req.max_row > act_m1) ? act_m1 : i_req.max_row;
    end

    always_comb begin
        at_top  = (r_idx == r_top);
        need    = {1'b0, r_k} + {{(rffsa_pkg::CNT_W-rffsa_pkg::SEAT_W+1){1'b0}}, r_rdata};
        sum_new = r_sum + rffsa_pkg::CNT_W'(r_rdata);
        sum_k   = {1'b0, sum_new} + {1'b0, r_k};
        avail   = (r_rdata >= r_spr) ? '0 : r_spr - r_rdata;
        take    = (r_k < rffsa_pkg::CNT_W'(avail)) ? r_k[rffsa_pkg::SEAT_W-1:0] : avail;
        n_idx   = r_idx;
        n_fill  = r_fill;
        n_k     = r_k;
        n_sum   = r_sum;
        n_res   = r_res;
        fin     = 1'b0;
        wr      = 1'b0;
        wdata   = '0;
        if (r_mode == rffsa_pkg::CMD_CONTIG) begin
            if (need <= {{(rffsa_pkg::CNT_W-rffsa_pkg::SEAT_W+1){1'b0}}, r_spr}) begin
                wr    = 1'b1;
                wdata = need[rffsa_pkg::SEAT_W-1:0];
                fin   = 1'b1;
                n_res = '{granted: 1'b1, row: r_idx, first_seat: r_rdata};
            end else if (at_top) begin
                fin = 1'b1;
            end else begin
                n_idx = r_idx + 1'b1;
            end
        end else if (!r_fill) begin
            n_sum = sum_new;
            if (at_top) begin
                if (sum_k > {1'b0, r_cap}) begin
                    fin = 1'b1;
                end else begin
                    n_fill = 1'b1;
                    n_idx  = '0;
                end
            end else begin
                n_idx = r_idx + 1'b1;
            end
        end else begin
            wr    = 1'b1;
            wdata = r_rdata + take;
            n_k   = r_k - rffsa_pkg::CNT_W'(take);
            if (n_k == '0 || at_top) begin
                fin           = 1'b1;
                n_res.granted = 1'b1;
            end else begin
                n_idx = r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) mem[r_idx] <= '0;
        else if (i_cmd.ev && wr) mem[r_idx] <= wdata;
        if (i_cmd.rd) r_rdata <= mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows   <= rffsa_pkg::RCNT_W'(rffsa_pkg::ROWS);
            r_spr    <= '1;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    rffsa_pkg::CFG_ROWS_IN_USE:
                        r_rows <= i_cfg_data[rffsa_pkg::RCNT_W-1:0];
                    rffsa_pkg::CFG_SEATS_PER_ROW:
                        r_spr <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.clr_init || i_cmd.start) r_idx <= '0;
            else if (i_cmd.clr_step) r_idx <= r_idx + 1'b1;
            else if (i_cmd.ev) r_idx <= n_idx;
            if (i_cmd.load) r_ovalid <= 1'b1;
            else if (!i_out_stall) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_mode <= i_req.command;
            r_k    <= i_req.seat_count;
            r_top  <= top_c;
            r_fill <= 1'b0;
            r_sum  <= '0;
            r_res  <= '0;
            r_cap  <= rffsa_pkg::CNT_W'({1'b0, top_c} + 1'b1) * rffsa_pkg::CNT_W'(r_spr);
        end else if (i_cmd.ev) begin
            r_fill <= n_fill;
            r_k    <= n_k;
            r_sum  <= n_sum;
            r_res  <= n_res;
        end
        if (i_cmd.load) r_out <= r_res;
    end

    assign o_sts.clr_last = &r_idx;
    assign o_sts.finish   = fin;
    assign o_sts.out_free = !r_ovalid || !i_out_stall;
    assign o_out_valid    = r_ovalid;
    assign o_rsp          = r_out;

endmodule

### rtl/row_first_fit_seat_allocator.sv
// Each row scanned takes a read state then an evaluate state; the result then loads.
// A contiguous beat scans up to max_row+1 rows (clamped); a scattered beat sums rows
// 0..max_row, then fills from row 0.
// Throughput: one beat at a time; next beat accepted the cycle after the result loads.
// Reset (sync, active low) and any config write start a clearing pass of the
// row count memory; input is stalled during it. Results wait in an output register.
module row_first_fit_seat_allocator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rffsa_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rffsa_pkg::SEAT_W-1:0]      i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  rffsa_pkg::t_req                   i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output rffsa_pkg::t_rsp                   o_out_data
);

    rffsa_pkg::t_cmd cmd;
    rffsa_pkg::t_sts sts;

    // controller: clear sweep, read/evaluate loop per row, result hand-off
    rffsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath: row counts, sums, fit checks, output register
    rffsa_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_req       (i_in_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_rsp       (o_out_data),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

### rtl/rffsa_chk.sv
// Port-level checker for the seat allocator, bound to the top level.
module rffsa_chk (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_stall,
    input logic            o_out_valid,
    input logic            i_out_stall,
    input rffsa_pkg::t_rsp o_out_data
);

    // held result beat stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output beat dropped or changed while stalled");

    // a refusal carries no row or seat
    a_refuse_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.granted |->
            o_out_data.row == '0 && o_out_data.first_seat == '0)
        else $error("refused beat with nonzero row or seat");

    // one beat in flight: input stalls right after acceptance
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second beat accepted back to back");

    // no result without work: a result is not valid right after an accept with the output empty
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !o_out_valid |=> !o_out_valid)
        else $error("result appeared too early");

endmodule

bind row_first_fit_seat_allocator rffsa_chk u_rffsa_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

### tb/row_first_fit_seat_allocator_tb.sv
// Self-checking testbench for the row first-fit seat allocator.
`timescale 1ns / 100ps

module row_first_fit_seat_allocator_tb;

    // Booking predictor and queue of expected grants.
    class seat_board;
        int unsigned       rows_cfg;
        int unsigned       seats_cfg;
        int unsigned       used_cnt [rffsa_pkg::ROWS];
        int unsigned       open_row;
        rffsa_pkg::t_rsp   grants_due[$];
        int                errors;

        function void clear_hall();
            foreach (used_cnt[i]) used_cnt[i] = 0;
            open_row = 0;
        endfunction

        function void write_reg(logic [rffsa_pkg::CFG_IDX_W-1:0] idx,
                                logic [rffsa_pkg::SEAT_W-1:0] val);
            if (idx == rffsa_pkg::CFG_ROWS_IN_USE) rows_cfg = val & 16'h07FF;
            else seats_cfg = val;
            clear_hall();
        endfunction

        function void skip_full(int unsigned top);
            while (open_row <= top && open_row < rffsa_pkg::ROWS &&
                   used_cnt[open_row] >= seats_cfg)
                open_row++;
        endfunction

        // Work out the grant for one accepted request and update the hall.
        function void note_request(rffsa_pkg::t_req rq);
            rffsa_pkg::t_rsp rs;
            int unsigned     top, live;
            longint unsigned k, need_sum, cap, avail, take;
            rs = '0;
            live = (rows_cfg == 0) ? 1 :
                   (rows_cfg > rffsa_pkg::ROWS ? rffsa_pkg::ROWS : rows_cfg);
            top = rq.max_row;
            if (top > live - 1) top = live - 1;
            k = rq.seat_count;
            if (rq.command == rffsa_pkg::CMD_CONTIG) begin
                for (int unsigned i = 0; i <= top; i++) begin
                    if (used_cnt[i] + k <= seats_cfg) begin
                        rs.granted = 1'b1;
                        rs.row = i[rffsa_pkg::ROW_W-1:0];
                        rs.first_seat = used_cnt[i][rffsa_pkg::SEAT_W-1:0];
                        used_cnt[i] = (used_cnt[i] + k) & 16'hFFFF;
                        break;
                    end
                end
            end else begin
                need_sum = 0;
                cap = longint'(top + 1) * seats_cfg;
                for (int unsigned i = 0; i <= top; i++) need_sum += used_cnt[i];
                if (!(need_sum > cap || cap - need_sum < k)) begin
                    skip_full(top);
                    for (int unsigned i = open_row; i <= top && k > 0; i++) begin
                        avail = used_cnt[i] >= seats_cfg ? 0 : seats_cfg - used_cnt[i];
                        take = k < avail ? k : avail;
                        used_cnt[i] = (used_cnt[i] + take) & 16'hFFFF;
                        k -= take;
                    end
                    skip_full(top);
                    rs.granted = 1'b1;
                end
            end
            grants_due.push_back(rs);
        endfunction

        task check_grant(rffsa_pkg::t_rsp got);
            rffsa_pkg::t_rsp want;
            if (grants_due.size() == 0) begin
                report_miss("grant with nothing pending");
                return;
            end
            want = grants_due.pop_front();
            if (got.granted !== want.granted)
                report_miss($sformatf("granted %0b want %0b", got.granted, want.granted));
            if (got.row !== want.row)
                report_miss($sformatf("row %0d want %0d", got.row, want.row));
            if (got.first_seat !== want.first_seat)
                report_miss($sformatf("first_seat %0d want %0d",
                                      got.first_seat, want.first_seat));
        endtask

        task report_miss(string msg);
            errors++;
            $display("MISMATCH @%0t: %s", $realtime, msg);
        endtask
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [rffsa_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [rffsa_pkg::SEAT_W-1:0]    cfg_data;
    logic                            in_valid;
    logic                            in_stall;
    rffsa_pkg::t_req                 in_data;
    logic                            out_valid;
    logic                            out_stall;
    rffsa_pkg::t_rsp                 out_data;

    seat_board board;

    row_first_fit_seat_allocator dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    always begin
        clk = 1'b0; #1;
        clk = 1'b1; #1;
    end

    // Mostly short gaps, now and then a long one, sometimes none.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Output side: score every accepted grant beat, stall at random.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) board.check_grant(out_data);
    end

    initial begin
        int n;
        out_stall = 1'b1;
        @(posedge clk);
        forever begin
            n = gap_len();
            out_stall <= (n != 0);
            repeat (n) @(posedge clk);
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    task automatic send_req(logic cmd, logic [rffsa_pkg::CNT_W-1:0] cnt,
                            logic [rffsa_pkg::ROW_W-1:0] top);
        rffsa_pkg::t_req rq;
        int              n;
        n = gap_len();
        if (n != 0) begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        rq.command = cmd;
        rq.seat_count = cnt;
        rq.max_row = top;
        in_valid <= 1'b1;
        in_data  <= rq;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.note_request(rq);
    endtask

    // Let the queue drain, then let any clearing pass finish before a write.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.grants_due.size() != 0) @(posedge clk);
        repeat (4200) @(posedge clk);
    endtask

    task automatic write_cfg(logic [rffsa_pkg::CFG_IDX_W-1:0] idx,
                             logic [rffsa_pkg::SEAT_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we   <= 1'b0;
        board.write_reg(idx, val);
    endtask

    // Random requests sized to the hall; most succeed, some overflow.
    task automatic random_reqs(int cnt);
        logic [rffsa_pkg::CNT_W-1:0] k;
        logic [rffsa_pkg::ROW_W-1:0] top;
        int r;
        for (int i = 0; i < cnt; i++) begin
            r = $urandom_range(0, 99);
            if (r < 70) k = rffsa_pkg::CNT_W'($urandom_range(0, board.seats_cfg));
            else if (r < 85) k = rffsa_pkg::CNT_W'($urandom_range(0, board.seats_cfg * 4));
            else k = rffsa_pkg::CNT_W'($urandom);
            r = $urandom_range(0, 99);
            if (r < 60) top = rffsa_pkg::ROW_W'($urandom_range(0, 15));
            else top = rffsa_pkg::ROW_W'($urandom);
            send_req(1'($urandom_range(0, 1)), k, top);
        end
    endtask

    initial begin
        board = new();
        board.rows_cfg = 1024;
        board.seats_cfg = 65535;
        board.clear_hall();
        rst_n    = 1'b0;
        cfg_we   = 1'b0;
        cfg_idx  = rffsa_pkg::CFG_ROWS_IN_USE;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data  = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset hall, extremes of every field.
        send_req(rffsa_pkg::CMD_CONTIG,  26'd0,        10'd0);
        send_req(rffsa_pkg::CMD_CONTIG,  26'd65535,    10'd1023);
        send_req(rffsa_pkg::CMD_CONTIG,  26'd65536,    10'd1023);
        send_req(rffsa_pkg::CMD_SCATTER, 26'd0,        10'd5);
        send_req(rffsa_pkg::CMD_SCATTER, 26'h3FFFFFF,  10'd1023);
        send_req(rffsa_pkg::CMD_SCATTER, 26'd200000,   10'd7);
        send_req(rffsa_pkg::CMD_CONTIG,  26'd1,        10'd7);
        drain();

        // Small hall, rows clamp hard.
        write_cfg(rffsa_pkg::CFG_ROWS_IN_USE, 16'd4);
        write_cfg(rffsa_pkg::CFG_SEATS_PER_ROW, 16'd10);
        send_req(rffsa_pkg::CMD_CONTIG,  26'd10, 10'd1023);
        send_req(rffsa_pkg::CMD_CONTIG,  26'd11, 10'd1023);
        send_req(rffsa_pkg::CMD_SCATTER, 26'd25, 10'd1023);
        send_req(rffsa_pkg::CMD_SCATTER, 26'd6,  10'd3);
        send_req(rffsa_pkg::CMD_CONTIG,  26'd0,  10'd3);
        send_req(rffsa_pkg::CMD_SCATTER, 26'd0,  10'd3);
        drain();

        // Rows register zero acts as one; above ROWS saturates; zero seats.
        write_cfg(rffsa_pkg::CFG_ROWS_IN_USE, 16'd0);
        send_req(rffsa_pkg::CMD_CONTIG, 26'd3, 10'd9);
        drain();
        write_cfg(rffsa_pkg::CFG_ROWS_IN_USE, 16'h07FF);
        write_cfg(rffsa_pkg::CFG_SEATS_PER_ROW, 16'd0);
        send_req(rffsa_pkg::CMD_CONTIG,  26'd1, 10'd3);
        send_req(rffsa_pkg::CMD_SCATTER, 26'd1, 10'd3);
        send_req(rffsa_pkg::CMD_CONTIG,  26'd0, 10'd3);
        drain();

        // Random phases across several hall shapes.
        write_cfg(rffsa_pkg::CFG_ROWS_IN_USE, 16'd8);
        write_cfg(rffsa_pkg::CFG_SEATS_PER_ROW, 16'd16);
        random_reqs(150);
        drain();
        write_cfg(rffsa_pkg::CFG_ROWS_IN_USE, 16'd1);
        write_cfg(rffsa_pkg::CFG_SEATS_PER_ROW, 16'd65535);
        random_reqs(60);
        drain();
        write_cfg(rffsa_pkg::CFG_ROWS_IN_USE, 16'd32);
        write_cfg(rffsa_pkg::CFG_SEATS_PER_ROW, 16'd1);
        random_reqs(80);
        drain();
        write_cfg(rffsa_pkg::CFG_ROWS_IN_USE, 16'd1024);
        write_cfg(rffsa_pkg::CFG_SEATS_PER_ROW, 16'd100);
        random_reqs(80);
        drain();
        write_cfg(rffsa_pkg::CFG_ROWS_IN_USE, 16'd12);
        write_cfg(rffsa_pkg::CFG_SEATS_PER_ROW, 16'($urandom));
        random_reqs(80);
        drain();

        if (board.errors == 0 && board.grants_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Run limit, far above the slowest correct run.
    initial begin
        #40000000;
        $display("simulation failed");
        $finish;
    end

endmodule
